// ===== design/dbdf_pkg.sv =====
// dbdf_pkg: shared types, codes and size helpers of the double buffer diff flush block
// no dependencies; imported by every module of the block except dbdf_ram
`default_nettype none

package dbdf_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 64;
    localparam int DEF_PANEL_COLUMNS = 64;

    localparam int PAGE_ROWS   = 8;
    localparam int FUNC_W      = 3;
    localparam int XY_W        = 8;
    localparam int COLUMN_W    = 6;
    localparam int PAGE_W      = 3;
    localparam int DATA_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int XY_RANGE    = 256;

    typedef enum logic [FUNC_W-1:0] {
        OP_SET    = 3'd0,
        OP_CLR    = 3'd1,
        OP_WIPE   = 3'd2,
        OP_FLUSH  = 3'd3,
        OP_TOGGLE = 3'd4
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [2:0]          bit_idx;
        logic                panel;
        logic [COLUMN_W-1:0] column;
    } t_cmd_ctl;

    function automatic int page_count(input int height);
        return (height + PAGE_ROWS - 1) / PAGE_ROWS;
    endfunction

    function automatic int buf_bytes(input int width, input int height);
        return page_count(height) * width;
    endfunction

    function automatic int addr_width(input int width, input int height);
        return $clog2(buf_bytes(width, height));
    endfunction

    function automatic int page_cnt_width(input int height);
        return (page_count(height) > 1) ? $clog2(page_count(height)) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== design/dbdf_ram.sv =====
// dbdf_ram: generic single write port, single read port memory with registered read
// no dependencies
`default_nettype none

module dbdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/dbdf_front.sv =====
// dbdf_front: input stage; accepts items, drops those with no effect, builds commands
// depends on dbdf_pkg
`default_nettype none

module dbdf_front #(
    parameter int SCREEN_WIDTH  = dbdf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = dbdf_pkg::DEF_SCREEN_HEIGHT,
    parameter int PANEL_COLUMNS = dbdf_pkg::DEF_PANEL_COLUMNS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_hold,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [dbdf_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [dbdf_pkg::XY_W-1:0]      i_x,
    input  wire logic [dbdf_pkg::XY_W-1:0]      i_y,
    output logic                                o_cmd_valid,
    input  wire logic                           i_cmd_ready,
    output dbdf_pkg::t_cmd_ctl                  o_cmd_ctl,
    output logic [dbdf_pkg::addr_width(SCREEN_WIDTH, SCREEN_HEIGHT)-1:0] o_cmd_addr
);

    import dbdf_pkg::*;

    localparam int AW = addr_width(SCREEN_WIDTH, SCREEN_HEIGHT);

    logic [COLUMN_W:0] w_pc_tbl [XY_RANGE];
    logic              w_x_ok;
    logic              w_y_ok;
    logic              w_keep;
    logic              w_accept;
    logic [AW-1:0]     w_addr;
    t_cmd_ctl          w_ctl;

    logic              r_valid;
    t_cmd_ctl          r_ctl;
    logic [AW-1:0]     r_addr;

    // panel select and in-panel column for every possible x
    for (genvar gi = 0; gi < XY_RANGE; gi++) begin : g_pc
        assign w_pc_tbl[gi] = {1'((gi / PANEL_COLUMNS) % 2),
                               COLUMN_W'((gi % PANEL_COLUMNS) % (2 ** COLUMN_W))};
    end

    assign w_x_ok = 32'(i_x) < 32'(SCREEN_WIDTH);
    assign w_y_ok = 32'(i_y) < 32'(SCREEN_HEIGHT);

    always_comb begin
        w_ctl.op      = t_op'(i_func);
        w_ctl.bit_idx = i_y[2:0];
        w_ctl.panel   = w_pc_tbl[i_x][COLUMN_W];
        w_ctl.column  = w_pc_tbl[i_x][COLUMN_W-1:0];
        w_addr        = AW'(i_x);
        w_keep        = 1'b0;
        case (i_func) inside
            OP_SET, OP_CLR: begin
                w_keep = w_x_ok && w_y_ok;
                w_addr = AW'(32'(i_y >> 3) * 32'(SCREEN_WIDTH) + 32'(i_x));
            end
            OP_WIPE, OP_TOGGLE: begin
                w_keep = 1'b1;
            end
            OP_FLUSH: begin
                w_keep = w_x_ok;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign o_ready  = !i_hold && (!r_valid || i_cmd_ready);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= w_keep;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
        if (w_accept) begin
            r_ctl  <= w_ctl;
            r_addr <= w_addr;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd_ctl   = r_ctl;
    assign o_cmd_addr  = r_addr;

endmodule

`default_nettype wire

// ===== design/dbdf_queue.sv =====
// dbdf_queue: short command queue between the front and the back
// depends on dbdf_pkg
`default_nettype none

module dbdf_queue #(
    parameter int WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data
);

    import dbdf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/dbdf_back.sv =====
// dbdf_back: command sequencer; owns both frame buffers, draw select and the result register
// depends on dbdf_pkg and dbdf_ram
`default_nettype none

module dbdf_back #(
    parameter int SCREEN_WIDTH  = dbdf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = dbdf_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    output logic                                o_init,
    input  wire logic                           i_cmd_valid,
    output logic                                o_cmd_pop,
    input  wire dbdf_pkg::t_cmd_ctl             i_cmd_ctl,
    input  wire logic [dbdf_pkg::addr_width(SCREEN_WIDTH, SCREEN_HEIGHT)-1:0] i_cmd_addr,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_panel,
    output logic [dbdf_pkg::COLUMN_W-1:0]       o_column,
    output logic [dbdf_pkg::PAGE_W-1:0]         o_page,
    output logic [dbdf_pkg::DATA_W-1:0]         o_data,
    output logic                                o_last
);

    import dbdf_pkg::*;

    localparam int AW    = addr_width(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam int DEPTH = buf_bytes(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam int PAGES = page_count(SCREEN_HEIGHT);
    localparam int PW    = page_cnt_width(SCREEN_HEIGHT);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PIX,
        ST_WIPE,
        ST_FL_CMP,
        ST_FL_END
    } t_state;

    t_state              r_state, n_state;
    logic                r_draw, n_draw;
    logic [AW-1:0]       r_addr, n_addr;
    logic [PW-1:0]       r_page, n_page;
    logic                r_set, n_set;
    logic [2:0]          r_bit, n_bit;
    logic                r_panel, n_panel;
    logic [COLUMN_W-1:0] r_column, n_column;
    logic                r_pend_valid, n_pend_valid;
    logic [PAGE_W-1:0]   r_pend_page, n_pend_page;
    logic [DATA_W-1:0]   r_pend_data, n_pend_data;
    logic                r_out_valid, n_out_valid;
    logic                r_out_panel, n_out_panel;
    logic [COLUMN_W-1:0] r_out_column, n_out_column;
    logic [PAGE_W-1:0]   r_out_page, n_out_page;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic                r_out_last, n_out_last;

    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic                w_wr;
    logic                w_wr_all;
    logic [DATA_W-1:0]   w_wr_data;
    logic [DATA_W-1:0]   w_rd0;
    logic [DATA_W-1:0]   w_rd1;
    logic [DATA_W-1:0]   w_rd_draw;
    logic [DATA_W-1:0]   w_mask;
    logic                w_can_push;
    logic                w_diff;
    logic                w_stall;
    logic [AW-1:0]       w_next_addr;

    dbdf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_buf0 (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr && (w_wr_all || !r_draw)),
        .i_wr_addr (r_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd0)
    );

    dbdf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_buf1 (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr && (w_wr_all || r_draw)),
        .i_wr_addr (r_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd1)
    );

    assign w_rd_draw   = r_draw ? w_rd1 : w_rd0;
    assign w_mask      = DATA_W'(1) << r_bit;
    assign w_can_push  = !r_out_valid || i_ready;
    assign w_diff      = w_rd0 != w_rd1;
    assign w_stall     = w_diff && r_pend_valid && !w_can_push;
    assign w_next_addr = r_addr + AW'(SCREEN_WIDTH);

    always_comb begin
        n_state      = r_state;
        n_draw       = r_draw;
        n_addr       = r_addr;
        n_page       = r_page;
        n_set        = r_set;
        n_bit        = r_bit;
        n_panel      = r_panel;
        n_column     = r_column;
        n_pend_valid = r_pend_valid;
        n_pend_page  = r_pend_page;
        n_pend_data  = r_pend_data;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_panel  = r_out_panel;
        n_out_column = r_out_column;
        n_out_page   = r_out_page;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_addr;
        w_wr         = 1'b0;
        w_wr_all     = 1'b0;
        w_wr_data    = '0;
        o_cmd_pop    = 1'b0;

        case (r_state)
            ST_INIT: begin
                w_wr     = 1'b1;
                w_wr_all = 1'b1;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_addr    = i_cmd_addr;
                    n_set     = i_cmd_ctl.op == OP_SET;
                    n_bit     = i_cmd_ctl.bit_idx;
                    n_panel   = i_cmd_ctl.panel;
                    n_column  = i_cmd_ctl.column;
                    case (i_cmd_ctl.op)
                        OP_SET, OP_CLR: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = i_cmd_addr;
                            n_state   = ST_PIX;
                        end
                        OP_WIPE: begin
                            n_addr  = '0;
                            n_state = ST_WIPE;
                        end
                        OP_FLUSH: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = i_cmd_addr;
                            n_page    = '0;
                            n_state   = ST_FL_CMP;
                        end
                        OP_TOGGLE: begin
                            n_draw = !r_draw;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PIX: begin
                w_wr      = 1'b1;
                w_wr_data = r_set ? (w_rd_draw | w_mask) : (w_rd_draw & ~w_mask);
                n_state   = ST_IDLE;
            end
            ST_WIPE: begin
                w_wr = 1'b1;
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_FL_CMP: begin
                if (!w_stall) begin
                    if (w_diff) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_panel  = r_panel;
                            n_out_column = r_column;
                            n_out_page   = r_pend_page;
                            n_out_data   = r_pend_data;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_page  = PAGE_W'(r_page);
                        n_pend_data  = w_rd_draw;
                    end
                    if (r_page == PW'(PAGES - 1)) begin
                        n_state = ST_FL_END;
                    end else begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_next_addr;
                        n_addr    = w_next_addr;
                        n_page    = r_page + 1'b1;
                    end
                end
            end
            ST_FL_END: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (w_can_push) begin
                    n_out_valid  = 1'b1;
                    n_out_panel  = r_panel;
                    n_out_column = r_column;
                    n_out_page   = r_pend_page;
                    n_out_data   = r_pend_data;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_draw       <= 1'b0;
            r_addr       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_draw       <= n_draw;
            r_addr       <= n_addr;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_page       <= n_page;
        r_set        <= n_set;
        r_bit        <= n_bit;
        r_panel      <= n_panel;
        r_column     <= n_column;
        r_pend_page  <= n_pend_page;
        r_pend_data  <= n_pend_data;
        r_out_panel  <= n_out_panel;
        r_out_column <= n_out_column;
        r_out_page   <= n_out_page;
        r_out_data   <= n_out_data;
        r_out_last   <= n_out_last;
    end

    assign o_init   = r_state == ST_INIT;
    assign o_valid  = r_out_valid;
    assign o_panel  = r_out_panel;
    assign o_column = r_out_column;
    assign o_page   = r_out_page;
    assign o_data   = r_out_data;
    assign o_last   = r_out_last;

endmodule

`default_nettype wire

// ===== design/double_buffer_diff_flush_top.sv =====
// double_buffer_diff_flush_top: two page-wise frame buffers with per-column diff flush
// depends on dbdf_pkg, dbdf_front, dbdf_queue, dbdf_back, dbdf_ram
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_func, i_x, i_y
//  out     | output    | o_out_valid / i_out_ready| o_panel, o_column, o_page, o_data, o_last
//
// set or clear pixel is a read-modify-write of the draw buffer (read in idle, write in ST_PIX),
// flush compares one page per cycle on both buffers unless stalled by a full result register,
// toggle flips the draw select in idle, clear of the draw buffer writes zero to all its bytes.
// after reset a clearing pass zeroes all pages * width bytes of both buffers with o_in_ready low.
// a two-entry command queue lets the input side keep accepting while results wait on i_out_ready.
`default_nettype none

module double_buffer_diff_flush_top #(
    parameter int SCREEN_WIDTH  = dbdf_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = dbdf_pkg::DEF_SCREEN_HEIGHT,
    parameter int PANEL_COLUMNS = dbdf_pkg::DEF_PANEL_COLUMNS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [dbdf_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [dbdf_pkg::XY_W-1:0]     i_x,
    input  wire logic [dbdf_pkg::XY_W-1:0]     i_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_panel,
    output logic [dbdf_pkg::COLUMN_W-1:0]      o_column,
    output logic [dbdf_pkg::PAGE_W-1:0]        o_page,
    output logic [dbdf_pkg::DATA_W-1:0]        o_data,
    output logic                               o_last
);

    import dbdf_pkg::*;

    localparam int AW   = addr_width(SCREEN_WIDTH, SCREEN_HEIGHT);
    localparam int QW   = $bits(t_cmd_ctl) + AW;

    logic          w_init;
    logic          w_fr_valid;
    logic          w_q_ready;
    t_cmd_ctl      w_fr_ctl;
    logic [AW-1:0] w_fr_addr;
    logic          w_q_valid;
    logic          w_q_pop;
    logic [QW-1:0] w_q_data;
    t_cmd_ctl      w_bk_ctl;
    logic [AW-1:0] w_bk_addr;

    dbdf_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PANEL_COLUMNS (PANEL_COLUMNS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (w_init),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_func      (i_func),
        .i_x         (i_x),
        .i_y         (i_y),
        .o_cmd_valid (w_fr_valid),
        .i_cmd_ready (w_q_ready),
        .o_cmd_ctl   (w_fr_ctl),
        .o_cmd_addr  (w_fr_addr)
    );

    dbdf_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_valid),
        .o_ready (w_q_ready),
        .i_data  ({w_fr_ctl, w_fr_addr}),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data)
    );

    assign w_bk_ctl  = t_cmd_ctl'(w_q_data[QW-1:AW]);
    assign w_bk_addr = w_q_data[AW-1:0];

    dbdf_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_init      (w_init),
        .i_cmd_valid (w_q_valid),
        .o_cmd_pop   (w_q_pop),
        .i_cmd_ctl   (w_bk_ctl),
        .i_cmd_addr  (w_bk_addr),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_panel     (o_panel),
        .o_column    (o_column),
        .o_page      (o_page),
        .o_data      (o_data),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    a_no_input_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> !o_in_ready)
        else $error("input taken during clearing pass");

    a_no_result_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> !o_out_valid)
        else $error("result shown during clearing pass");

    a_no_pop_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_init |-> !w_q_pop)
        else $error("command popped during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for double_buffer_diff_flush_top with its own frame store model
// depends on dbdf_pkg and the block; a scoreboard class predicts panel writes per flush item
// directed edge cases first, then random draw/flush/toggle/wipe/noise under three idle mixes

module tb_top;
    import dbdf_pkg::*;

    localparam int WIDTH        = DEF_SCREEN_WIDTH;
    localparam int HEIGHT       = DEF_SCREEN_HEIGHT;
    localparam int PANEL_COLS   = DEF_PANEL_COLUMNS;
    localparam int PAGES        = (HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int RANDOM_EDITS = 210;
    localparam int TAIL_CYCLES  = 2 * PAGES * WIDTH + 64;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [FUNC_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct {
        logic                panel;
        logic [COLUMN_W-1:0] column;
        logic [PAGE_W-1:0]   page;
        logic [DATA_W-1:0]   data;
        logic                last;
    } t_panel_write;

    class flush_scoreboard;
        logic [DATA_W-1:0] frame [2][PAGES][WIDTH];
        logic              draw_sel;
        t_panel_write      pending [$];
        int                mismatches;
        int                writes_seen;
        int                edits;
        int                flushes;
        int                toggles;
        int                wipes;

        function new();
            draw_sel = 1'b0;
            foreach (frame[b, p, c]) begin
                frame[b][p][c] = '0;
            end
        endfunction

        task report(string what);
            mismatches++;
            $display("mismatch: %s", what);
        endtask

        // returns 1 for items the front end keeps (in-range edit or flush, wipe, toggle)
        function bit note_item(logic [FUNC_W-1:0] func, logic [XY_W-1:0] x,
                               logic [XY_W-1:0] y);
            int           p;
            int           last_page;
            int           panel_idx;
            int           col_idx;
            t_panel_write w;
            last_page = -1;
            case (func)
                OP_SET, OP_CLR: begin
                    if (x >= WIDTH || y >= HEIGHT) begin
                        return 1'b0;
                    end
                    frame[draw_sel][y / PAGE_ROWS][x][y % PAGE_ROWS] = (func == OP_SET);
                    edits++;
                    return 1'b1;
                end
                OP_WIPE: begin
                    for (p = 0; p < PAGES; p++) begin
                        for (int c = 0; c < WIDTH; c++) begin
                            frame[draw_sel][p][c] = '0;
                        end
                    end
                    wipes++;
                    return 1'b1;
                end
                OP_FLUSH: begin
                    if (x >= WIDTH) begin
                        return 1'b0;
                    end
                    for (p = 0; p < PAGES; p++) begin
                        if (frame[draw_sel][p][x] != frame[~draw_sel][p][x]) begin
                            last_page = p;
                        end
                    end
                    panel_idx = x / PANEL_COLS;
                    col_idx   = x % PANEL_COLS;
                    for (p = 0; p < PAGES; p++) begin
                        if (frame[draw_sel][p][x] != frame[~draw_sel][p][x]) begin
                            w.panel  = panel_idx[0];
                            w.column = col_idx[COLUMN_W-1:0];
                            w.page   = p[PAGE_W-1:0];
                            w.data   = frame[draw_sel][p][x];
                            w.last   = (p == last_page);
                            pending.push_back(w);
                        end
                    end
                    flushes++;
                    return 1'b1;
                end
                OP_TOGGLE: begin
                    draw_sel = ~draw_sel;
                    toggles++;
                    return 1'b1;
                end
                default: begin
                    return 1'b0;
                end
            endcase
        endfunction

        task check_write(logic panel, logic [COLUMN_W-1:0] column,
                         logic [PAGE_W-1:0] page, logic [DATA_W-1:0] data,
                         logic last);
            t_panel_write w;
            writes_seen++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected write panel %0d column %0d page %0d data %h",
                                 panel, column, page, data));
                return;
            end
            w = pending.pop_front();
            if (panel !== w.panel) begin
                report($sformatf("panel %0d, want %0d (column %0d page %0d)",
                                 panel, w.panel, w.column, w.page));
            end
            if (column !== w.column) begin
                report($sformatf("column %0d, want %0d (page %0d)", column, w.column, w.page));
            end
            if (page !== w.page) begin
                report($sformatf("page %0d, want %0d (column %0d)", page, w.page, w.column));
            end
            if (data !== w.data) begin
                report($sformatf("data %h, want %h (column %0d page %0d)",
                                 data, w.data, w.column, w.page));
            end
            if (last !== w.last) begin
                report($sformatf("last %0d, want %0d (column %0d page %0d)",
                                 last, w.last, w.column, w.page));
            end
        endtask
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [FUNC_W-1:0]   i_func      = '0;
    logic [XY_W-1:0]     i_x         = '0;
    logic [XY_W-1:0]     i_y         = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_panel;
    logic [COLUMN_W-1:0] o_column;
    logic [PAGE_W-1:0]   o_page;
    logic [DATA_W-1:0]   o_data;
    logic                o_last;

    int send_idle_pct = 35;
    int recv_idle_pct = 51;
    int cycle_count   = 0;
    int counted_items = 0;
    int items_sent    = 0;

    flush_scoreboard board = new();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    double_buffer_diff_flush_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_x         (i_x),
        .i_y         (i_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_panel     (o_panel),
        .o_column    (o_column),
        .o_page      (o_page),
        .o_data      (o_data),
        .o_last      (o_last)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes still pending",
                     cycle_count, board.pending.size());
            $display("double_buffer_diff_flush_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_write(o_panel, o_column, o_page, o_data, o_last);
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(logic [FUNC_W-1:0] func, logic [XY_W-1:0] x,
                             logic [XY_W-1:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_x        <= x;
        i_y        <= y;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        counted_items += board.note_item(func, x, y);
    endtask

    task automatic drain_results;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending.size() != 0);
    endtask

    // draw a few pixels into some columns, flush them, maybe show the frame
    task automatic edit_and_flush;
        logic [XY_W-1:0] cols [3];
        int              ncols;
        int              npix;
        ncols = $urandom_range(1, 3);
        for (int i = 0; i < ncols; i++) begin
            cols[i] = XY_W'($urandom_range(WIDTH - 1));
            npix    = $urandom_range(1, 8);
            for (int j = 0; j < npix; j++) begin
                send_item(($urandom_range(99) < 70) ? OP_SET : OP_CLR, cols[i],
                          XY_W'($urandom_range(HEIGHT - 1)));
            end
        end
        for (int i = 0; i < ncols; i++) begin
            send_item(OP_FLUSH, cols[i], XY_W'($urandom_range(255)));
        end
        if ($urandom_range(3) == 0) begin
            send_item(OP_FLUSH, XY_W'($urandom_range(WIDTH - 1)), XY_W'($urandom_range(255)));
        end
        if ($urandom_range(1) == 1) begin
            send_item(OP_TOGGLE, XY_W'($urandom_range(255)), XY_W'($urandom_range(255)));
        end
    endtask

    task automatic send_noise;
        case ($urandom_range(2))
            0: send_item(FUNC_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                         XY_W'($urandom_range(255)), XY_W'($urandom_range(255)));
            1: send_item(($urandom_range(1) == 1) ? OP_SET : OP_CLR,
                         XY_W'($urandom_range(255)), XY_W'($urandom_range(255)));
            default: send_item(OP_FLUSH, XY_W'($urandom_range(WIDTH, 255)),
                               XY_W'($urandom_range(255)));
        endcase
    endtask

    task automatic random_items(int target);
        int goal;
        int roll;
        goal = counted_items + target;
        while (counted_items < goal) begin
            roll = $urandom_range(99);
            if (roll < 3) begin
                send_item(OP_WIPE, XY_W'($urandom_range(255)), XY_W'($urandom_range(255)));
            end else if (roll < 15) begin
                send_noise();
            end else begin
                edit_and_flush();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners, out of range pixels, panel boundary, multi-page flush
        send_item(OP_SET,    8'd0,   8'd0);
        send_item(OP_SET,    8'd127, 8'd63);
        send_item(OP_SET,    8'd127, 8'd0);
        send_item(OP_SET,    8'd64,  8'd7);
        send_item(OP_SET,    8'd63,  8'd56);
        send_item(OP_SET,    8'd255, 8'd255);
        send_item(OP_SET,    8'd128, 8'd0);
        send_item(OP_SET,    8'd0,   8'd64);
        send_item(OP_FLUSH,  8'd0,   8'd0);
        send_item(OP_FLUSH,  8'd127, 8'd255);
        send_item(OP_FLUSH,  8'd64,  8'd0);
        send_item(OP_FLUSH,  8'd63,  8'd0);
        send_item(OP_FLUSH,  8'd255, 8'd0);
        send_item(OP_FLUSH,  8'd5,   8'd0);
        send_item(OP_CLR,    8'd0,   8'd0);
        send_item(OP_SET,    8'd0,   8'd9);
        send_item(OP_FLUSH,  8'd0,   8'd0);
        send_item(OP_TOGGLE, 8'd0,   8'd0);
        send_item(OP_FLUSH,  8'd127, 8'd0);
        send_item(OP_SPARE_FIRST,                  8'd255, 8'd255);
        send_item(FUNC_W'(OP_SPARE_FIRST + 3'd1), 8'd170, 8'd85);
        send_item(OP_SPARE_LAST,                   8'd85,  8'd170);
        send_item(OP_WIPE,   8'd0,   8'd0);
        send_item(OP_TOGGLE, 8'd0,   8'd0);
        send_item(OP_FLUSH,  8'd0,   8'd0);

        random_items(RANDOM_EDITS / 3);
        drain_results();

        send_idle_pct = 51;
        recv_idle_pct = 35;
        random_items(RANDOM_EDITS / 3);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(RANDOM_EDITS - 2 * (RANDOM_EDITS / 3));
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d items: %0d pixel edits, %0d flushes, %0d toggles, %0d buffer clears",
                 items_sent, board.edits, board.flushes, board.toggles, board.wipes);
        $display("checked %0d panel writes under sender, receiver and no idling, %0d mismatches",
                 board.writes_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("double_buffer_diff_flush_top test passed");
        end else begin
            $display("double_buffer_diff_flush_top test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/dbdf_pkg.sv
design/dbdf_ram.sv
design/dbdf_front.sv
design/dbdf_queue.sv
design/dbdf_back.sv
design/double_buffer_diff_flush_top.sv
sim/tb_top.sv
